[sv/rrh_pkg.sv]
package rrh_pkg;

	localparam int MESSAGE_BYTES_D  = 32;
	localparam int BIN_COUNT_D      = 5;
	localparam int MILESTONE_BITS_D = 24;

	localparam logic [63:0] MSG_RESET_WORD = 64'h0001_0001_0001_0001;
	localparam int IN_WORDS = 4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_WRITE,
		ST_START,
		ST_SCAN,
		ST_BIN,
		ST_DONE
	} rrh_state_t;

endpackage

[sv/rrh_ifs.sv]
interface rrh_in_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [63:0] word0;
	logic [63:0] word1;
	logic [63:0] word2;
	logic [63:0] word3;

	modport source (output valid, cmd, word0, word1, word2, word3, input ready);
	modport sink (input valid, cmd, word0, word1, word2, word3, output ready);
endinterface

interface rrh_out_if;
	logic        valid;
	logic        ready;
	logic [4:0]  byte_run;
	logic [3:0]  pair_run;
	logic [2:0]  score_bin;
	logic [63:0] bin_total;
	logic        milestone;
	logic        wrapped;

	modport source (output valid, byte_run, pair_run, score_bin, bin_total, milestone,
		wrapped, input ready);
	modport sink (input valid, byte_run, pair_run, score_bin, bin_total, milestone,
		wrapped, output ready);
endinterface

[sv/rrh_ram.sv]
module rrh_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[sv/rrh_scan.sv]
module rrh_scan import rrh_pkg::*; #(
	parameter int MESSAGE_BYTES = MESSAGE_BYTES_D,
	localparam int MSG_WORDS = (MESSAGE_BYTES + 7) / 8,
	localparam int MW = MSG_WORDS * 64,
	localparam int CW = $clog2(MESSAGE_BYTES + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [MW-1:0] msg,
	output logic          done,
	output logic [CW-1:0] byte_best,
	output logic [CW-1:0] pair_best
);

	localparam logic [CW-1:0] B_END  = CW'(MESSAGE_BYTES - 1);
	localparam logic [CW-1:0] P_END  = CW'(MESSAGE_BYTES - 2);
	localparam logic [CW-1:0] P_FULL = CW'(MESSAGE_BYTES - 3);

	logic [MW-1:0] bsr_q, psr_q;
	logic [CW-1:0] bi_q, pi_q;
	logic [CW-1:0] brun_q, bbest_q, prun_q, pbest_q;
	logic          busy_q, done_q;
	logic          b_act, p_act, b_eq, p_eq;

	assign b_act = busy_q && (bi_q < B_END);
	assign p_act = busy_q && (pi_q < P_END);
	assign b_eq  = bsr_q[7:0] == bsr_q[15:8];
	assign p_eq  = (pi_q < P_FULL) && (psr_q[7:0] == psr_q[23:16])
		&& (psr_q[15:8] == psr_q[31:24]);

	always_ff @(posedge clk) begin
		if (start) begin
			bsr_q <= msg;
			psr_q <= msg;
		end else begin
			if (b_act) begin
				bsr_q <= bsr_q >> 8;
			end
			if (p_act) begin
				psr_q <= p_eq ? (psr_q >> 16) : (psr_q >> 8);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			bi_q    <= '0;
			pi_q    <= '0;
			brun_q  <= '0;
			bbest_q <= '0;
			prun_q  <= '0;
			pbest_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				bi_q    <= '0;
				pi_q    <= '0;
				brun_q  <= '0;
				bbest_q <= '0;
				prun_q  <= '0;
				pbest_q <= '0;
			end else if (busy_q) begin
				if (b_act) begin
					bi_q <= bi_q + 1'b1;
					if (b_eq) begin
						brun_q <= brun_q + 1'b1;
						if (brun_q + 1'b1 > bbest_q) begin
							bbest_q <= brun_q + 1'b1;
						end
					end else begin
						brun_q <= '0;
					end
				end
				if (p_act) begin
					if (p_eq) begin
						pi_q   <= pi_q + CW'(2);
						prun_q <= prun_q + 1'b1;
						if (prun_q + 1'b1 > pbest_q) begin
							pbest_q <= prun_q + 1'b1;
						end
					end else begin
						pi_q   <= pi_q + 1'b1;
						prun_q <= '0;
					end
				end
				if (!b_act && !p_act) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done      = done_q;
	assign byte_best = bbest_q;
	assign pair_best = pbest_q;

endmodule

[sv/repeat_run_histogram_top.sv]
// Repeat-run histogram.
// in_ch (valid/ready): one beat carries cmd and word0..word3. cmd 0 adds one
// to the stored message, cmd 1 loads the words. The message is then scored:
// longest chain of equal adjacent bytes and longest chain of repeated byte
// pairs in a stride scan. The larger score, capped at the last bin, selects
// a 64-bit bin counter that is incremented.
// out_ch (valid/ready): one result beat per input beat, in order. An advance
// that wraps the message to zero returns wrapped = 1 with all other fields
// zero and touches no bin.
// The time from accept to result is set by the read-modify-write of the
// message memory, a read state then a write state per word, and the scan,
// which walks one byte position per cycle; a wrapping advance skips the
// scan. One item is in flight at a time; a new beat is taken the cycle after
// the previous result enters the output register.
// Reset: message words read as 0x0001000100010001 and bins as zero until
// first written; no clearing pass. A stalled receiver holds the result
// register, and the block holds the following item until it drains.
module repeat_run_histogram_top import rrh_pkg::*; #(
	parameter int MESSAGE_BYTES  = MESSAGE_BYTES_D,
	parameter int BIN_COUNT      = BIN_COUNT_D,
	parameter int MILESTONE_BITS = MILESTONE_BITS_D
) (
	input logic      clk,
	input logic      arst_n,
	rrh_in_if.sink   in_ch,
	rrh_out_if.source out_ch
);

	localparam int MSG_WORDS = (MESSAGE_BYTES + 7) / 8;
	localparam int MW  = MSG_WORDS * 64;
	localparam int WW  = (MSG_WORDS > 1) ? $clog2(MSG_WORDS) : 1;
	localparam int BW  = $clog2(BIN_COUNT);
	localparam int CW  = $clog2(MESSAGE_BYTES + 1);
	localparam int REM = MESSAGE_BYTES % 8;
	localparam logic [63:0] TOP_MASK = (REM == 0) ? '1 : ((64'd1 << (REM * 8)) - 64'd1);
	localparam logic [WW-1:0] W_LAST = WW'(MSG_WORDS - 1);

	rrh_state_t state_q, state_d;

	logic [IN_WORDS-1:0][63:0] in_word_q;
	logic                      cmd_q;
	logic [WW-1:0]             w_q;
	logic                      carry_q, zero_q, wrap_q;
	logic [MSG_WORDS-1:0][63:0] msg_q;
	logic [MSG_WORDS-1:0]      mvalid_q;
	logic [BIN_COUNT-1:0]      bvalid_q;
	logic [BW-1:0]             sel_q;
	logic [4:0]                byte_sat_q;
	logic [3:0]                pair_sat_q;
	logic [2:0]                score_q;
	logic [63:0]               total_q;

	logic                      out_valid_q;
	logic [4:0]                out_byte_q;
	logic [3:0]                out_pair_q;
	logic [2:0]                out_score_q;
	logic [63:0]               out_total_q;
	logic                      out_mile_q, out_wrap_q;

	logic        accept, out_free;
	logic [63:0] m_rdata, b_rdata;
	logic        m_re, m_we, b_re, b_we, scan_start, scan_done;
	logic [CW-1:0] byte_best, pair_best;
	logic [31:0] w32, b32, p32, m32, s32;
	logic [63:0] old_word, sum_word, raw_word, new_word, bin_old, bin_new;
	logic        carry_next, zero_next;

	assign out_free = !out_valid_q || out_ch.ready;
	assign accept   = in_ch.valid && in_ch.ready;

	// message word update
	assign w32      = 32'(w_q);
	assign old_word = mvalid_q[w_q] ? m_rdata
		: ((w_q == W_LAST) ? (MSG_RESET_WORD & TOP_MASK) : MSG_RESET_WORD);
	assign sum_word = old_word + {63'd0, carry_q};
	assign raw_word = cmd_q ? ((w32 < 32'(IN_WORDS)) ? in_word_q[w32[1:0]] : 64'd0)
		: sum_word;
	assign new_word   = (w_q == W_LAST) ? (raw_word & TOP_MASK) : raw_word;
	assign carry_next = carry_q && (sum_word == 64'd0);
	assign zero_next  = zero_q && (new_word == 64'd0);

	// bin choice
	assign b32 = 32'(byte_best);
	assign p32 = 32'(pair_best);
	assign m32 = (p32 > b32) ? p32 : b32;
	assign s32 = (m32 > 32'(BIN_COUNT - 1)) ? 32'(BIN_COUNT - 1) : m32;

	assign bin_old = bvalid_q[sel_q] ? b_rdata : 64'd0;
	assign bin_new = bin_old + 64'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ch.ready = 1'b0;
		m_re        = 1'b0;
		m_we        = 1'b0;
		b_re        = 1'b0;
		b_we        = 1'b0;
		scan_start  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ch.ready = 1'b1;
				if (in_ch.valid) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				m_re    = 1'b1;
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				m_we = 1'b1;
				if (w_q == W_LAST) begin
					state_d = (!cmd_q && zero_next) ? ST_DONE : ST_START;
				end else begin
					state_d = ST_READ;
				end
			end
			ST_START: begin
				scan_start = 1'b1;
				state_d    = ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_done) begin
					b_re    = 1'b1;
					state_d = ST_BIN;
				end
			end
			ST_BIN: begin
				b_we    = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mvalid_q    <= '0;
			bvalid_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (m_we) begin
				mvalid_q[w_q] <= 1'b1;
			end
			if (b_we) begin
				bvalid_q[sel_q] <= 1'b1;
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q        <= in_ch.cmd;
			in_word_q[0] <= in_ch.word0;
			in_word_q[1] <= in_ch.word1;
			in_word_q[2] <= in_ch.word2;
			in_word_q[3] <= in_ch.word3;
			w_q          <= '0;
			carry_q      <= 1'b1;
			zero_q       <= 1'b1;
			wrap_q       <= 1'b0;
		end
		if (m_we) begin
			msg_q[w_q] <= new_word;
			carry_q    <= carry_next;
			zero_q     <= zero_next;
			w_q        <= w_q + 1'b1;
			wrap_q     <= (w_q == W_LAST) && !cmd_q && zero_next;
		end
		if (b_re) begin
			sel_q      <= s32[BW-1:0];
			score_q    <= s32[2:0];
			byte_sat_q <= (b32 > 32'd31) ? 5'd31 : b32[4:0];
			pair_sat_q <= (p32 > 32'd15) ? 4'd15 : p32[3:0];
		end
		if (b_we) begin
			total_q <= bin_new;
		end
		if (state_q == ST_DONE && out_free) begin
			out_wrap_q  <= wrap_q;
			out_byte_q  <= wrap_q ? 5'd0 : byte_sat_q;
			out_pair_q  <= wrap_q ? 4'd0 : pair_sat_q;
			out_score_q <= wrap_q ? 3'd0 : score_q;
			out_total_q <= wrap_q ? 64'd0 : total_q;
			out_mile_q  <= !wrap_q && (total_q[MILESTONE_BITS-1:0] == '0);
		end
	end

	rrh_ram #(
		.WIDTH (64),
		.DEPTH (MSG_WORDS)
	) u_msg_ram (
		.clk   (clk),
		.we    (m_we),
		.waddr (w_q),
		.wdata (new_word),
		.re    (m_re),
		.raddr (w_q),
		.rdata (m_rdata)
	);

	rrh_ram #(
		.WIDTH (64),
		.DEPTH (BIN_COUNT)
	) u_bin_ram (
		.clk   (clk),
		.we    (b_we),
		.waddr (sel_q),
		.wdata (bin_new),
		.re    (b_re),
		.raddr (s32[BW-1:0]),
		.rdata (b_rdata)
	);

	rrh_scan #(
		.MESSAGE_BYTES (MESSAGE_BYTES)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (scan_start),
		.msg       (MW'(msg_q)),
		.done      (scan_done),
		.byte_best (byte_best),
		.pair_best (pair_best)
	);

	assign out_ch.valid     = out_valid_q;
	assign out_ch.byte_run  = out_byte_q;
	assign out_ch.pair_run  = out_pair_q;
	assign out_ch.score_bin = out_score_q;
	assign out_ch.bin_total = out_total_q;
	assign out_ch.milestone = out_mile_q;
	assign out_ch.wrapped   = out_wrap_q;

endmodule
